// ===== sv/jrr_pkg.sv =====
// Shared types, constants and fixed-point helpers for the J2 radial return core.
package jrr_pkg;

   localparam int NUM_LANES = 6;
   localparam int NUM_DIAG = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int SQRT_STEPS = 32;
   localparam logic [31:0] SQRT_TWO_THIRDS_Q32 = 32'd3506826112;

   typedef logic signed [31:0] q16_type;

   typedef enum logic [1:0] {
      REG_LAME_LAMBDA   = 2'd0,
      REG_SHEAR_MODULUS = 2'd1,
      REG_YIELD_STRESS  = 2'd2
   } csr_reg_type;

   // Step strobes from the sequencer, shared by all lanes
   typedef struct packed {
      logic load;
      logic mul1;
      logic rate;
      logic mul2;
      logic trial;
      logic dev;
      logic square;
      logic prep;
      logic div_go;
      logic commit;
   } lane_ctl_type;

   typedef struct packed {
      logic       mean_go;
      logic       acc_clr;
      logic       acc_en;
      logic [2:0] acc_sel;
      logic       root_go;
   } merge_ctl_type;

   typedef struct packed {
      logic mean_busy;
      logic root_busy;
   } merge_stat_type;

   // Saturate to signed 32 bits
   function automatic q16_type sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return q16_type'(v[31:0]);
      end
   endfunction

   // Drop 16 fraction bits of a product, round half up, saturate
   function automatic q16_type mulq(input logic signed [65:0] p);
      logic signed [65:0] t;
      t = (p + 66'sd32768) >>> 16;
      return sat32(t);
   endfunction

endpackage

// ===== sv/jrr_req_if.sv =====
// Input channel: deformation rate components and time step.
interface jrr_req_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] rate_xx;
   logic signed [31:0] rate_yy;
   logic signed [31:0] rate_zz;
   logic signed [31:0] rate_xy;
   logic signed [31:0] rate_yz;
   logic signed [31:0] rate_xz;
   logic [31:0] time_step;

   modport source (output valid, rate_xx, rate_yy, rate_zz, rate_xy, rate_yz, rate_xz,
                   time_step, input ready);
   modport sink (input valid, rate_xx, rate_yy, rate_zz, rate_xy, rate_yz, rate_xz,
                 time_step, output ready);
endinterface

// ===== sv/jrr_rsp_if.sv =====
// Result channel: updated stress components and yield flag.
interface jrr_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] stress_xx;
   logic signed [31:0] stress_yy;
   logic signed [31:0] stress_zz;
   logic signed [31:0] stress_xy;
   logic signed [31:0] stress_yz;
   logic signed [31:0] stress_xz;
   logic        yielded;

   modport source (output valid, stress_xx, stress_yy, stress_zz, stress_xy, stress_yz,
                   stress_xz, yielded, input ready);
   modport sink (input valid, stress_xx, stress_yy, stress_zz, stress_xy, stress_yz,
                 stress_xz, yielded, output ready);
endinterface

// ===== sv/jrr_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module jrr_divider #(
   parameter int DVD_W = 64,
   parameter int DVS_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DVS_W:0]   part;
   logic [DVS_W:0]   diff;
   logic             fits;

   // Shift one dividend bit into the partial remainder, subtract when it fits
   always_comb begin
      part = {rem_ff, quo_ff[DVD_W-1]};
      diff = part - {1'b0, divisor};
      fits = (part >= {1'b0, divisor});
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : part[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/jrr_lane.sv =====
// One stress component: trial stress, deviator, square and radial scaling.
module jrr_lane import jrr_pkg::*; #(
   parameter bit IS_DIAG = 1'b1
) (
   input  logic         clock,
   input  logic         reset,
   input  lane_ctl_type ctl,
   input  q16_type      rate_comp,
   input  logic [31:0]  dt,
   input  q16_type      m2,
   input  q16_type      lt,
   input  q16_type      mean,
   input  logic [30:0]  k,
   input  logic [31:0]  norm,
   input  logic         yielded,
   output q16_type      trial,
   output logic [63:0]  sq,
   output q16_type      res,
   output logic         busy
);

   q16_type            d_ff, d_in;
   logic signed [65:0] prod_ff, prod_in;
   q16_type            rate_ff, rate_in;
   q16_type            trial_ff, trial_in;
   logic signed [32:0] s_ff, s_in;
   logic [63:0]        sq_ff, sq_in;
   logic [63:0]        dvd_ff, dvd_in;
   q16_type            stress_ff, stress_in;

   logic signed [63:0] p1;
   logic signed [64:0] p2;
   logic signed [65:0] rsum;
   logic [32:0]        s_neg;
   logic [31:0]        mag;
   logic [63:0]        quo;
   logic signed [33:0] qv;

   jrr_divider #(.DVD_W(64), .DVS_W(32)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_go),
      .dividend (dvd_ff),
      .divisor  (norm),
      .busy     (busy),
      .quotient (quo)
   );

   always_comb begin
      p1 = m2 * d_ff;
      p2 = rate_ff * $signed({1'b0, dt});
      rsum = 66'(lt) + 66'(mulq(prod_ff));
      s_neg = -s_ff;
      mag = s_ff[32] ? s_neg[31:0] : s_ff[31:0];

      // Scaled deviator, sign restored
      qv = $signed({2'b00, quo[31:0]});
      if (s_ff[32]) begin
         qv = -qv;
      end
      if (!yielded) begin
         res = trial_ff;
      end else if (IS_DIAG) begin
         res = sat32(66'(mean) + 66'(qv));
      end else begin
         res = sat32(66'(qv));
      end

      d_in = ctl.load ? rate_comp : d_ff;

      // One product register, shared by the two product steps
      prod_in = prod_ff;
      if (ctl.mul1) begin
         prod_in = 66'(p1);
      end else if (ctl.mul2) begin
         prod_in = 66'(p2);
      end

      rate_in = rate_ff;
      if (ctl.rate) begin
         rate_in = IS_DIAG ? sat32(rsum) : mulq(prod_ff);
      end

      trial_in = trial_ff;
      if (ctl.trial) begin
         trial_in = sat32(66'(stress_ff) + 66'(mulq(prod_ff)));
      end

      s_in = s_ff;
      if (ctl.dev) begin
         s_in = IS_DIAG ? (33'(trial_ff) - 33'(mean)) : 33'(trial_ff);
      end

      sq_in = ctl.square ? (64'(mag) * 64'(mag)) : sq_ff;
      dvd_in = ctl.prep ? (64'(mag) * 64'(k) + 64'(norm[31:1])) : dvd_ff;
      stress_in = ctl.commit ? res : stress_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stress_ff <= '0;
      end else begin
         stress_ff <= stress_in;
      end
      d_ff <= d_in;
      prod_ff <= prod_in;
      rate_ff <= rate_in;
      trial_ff <= trial_in;
      s_ff <= s_in;
      sq_ff <= sq_in;
      dvd_ff <= dvd_in;
   end

   assign trial = trial_ff;
   assign sq = sq_ff;

endmodule

// ===== sv/jrr_merge.sv =====
// Lane merge: mean stress, deviator norm square root and yield radius.
module jrr_merge import jrr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  merge_ctl_type  ctl,
   input  q16_type        diag_trial [NUM_DIAG],
   input  logic [63:0]    lane_sq [NUM_LANES],
   input  logic [30:0]    yield_stress,
   output q16_type        mean,
   output logic [31:0]    norm,
   output logic [30:0]    k,
   output merge_stat_type stat
);

   // ceil(2^35 / 3), split in two halves so each multiply stays small
   localparam logic [16:0] RECIP_HI = 17'h1_5555;
   localparam logic [16:0] RECIP_LO = 17'h0_AAAB;

   logic signed [33:0] t3;
   logic [33:0]        t3_neg;
   logic [33:0]        x;
   logic [67:0]        recip_prod;
   logic signed [33:0] mv;

   logic               neg_ff, neg_in;
   logic [50:0]        pp_hi_ff, pp_hi_in;
   logic [50:0]        pp_lo_ff, pp_lo_in;
   logic [32:0]        mquo_ff, mquo_in;
   logic               mean_busy_ff, mean_busy_in;
   logic [30:0]        k_ff, k_in;
   logic [66:0]        acc_ff, acc_in;
   logic [64:0]        addend;
   logic [63:0]        v_ff, v_in;
   logic [63:0]        r_ff, r_in;
   logic [63:0]        b_ff, b_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               root_busy_ff, root_busy_in;
   logic [64:0]        rb;
   logic [63:0]        kp;

   // Mean: |t3| + 1 divided by three through a reciprocal multiply, sign restored
   always_comb begin
      t3 = 34'(diag_trial[0]) + 34'(diag_trial[1]) + 34'(diag_trial[2]);
      t3_neg = -t3;
      x = (t3[33] ? t3_neg : t3) + 34'd1;
      neg_in = ctl.mean_go ? t3[33] : neg_ff;
      pp_hi_in = ctl.mean_go ? (51'(x) * 51'(RECIP_HI)) : pp_hi_ff;
      pp_lo_in = ctl.mean_go ? (51'(x) * 51'(RECIP_LO)) : pp_lo_ff;
      mean_busy_in = ctl.mean_go;
      recip_prod = {pp_hi_ff, 17'b0} + 68'(pp_lo_ff);
      mquo_in = mean_busy_ff ? recip_prod[67:35] : mquo_ff;
      mv = neg_ff ? -$signed({1'b0, mquo_ff}) : $signed({1'b0, mquo_ff});
   end

   // Yield radius and the running sum of squares
   always_comb begin
      kp = 64'(yield_stress) * 64'(SQRT_TWO_THIRDS_Q32) + 64'h80000000;
      k_in = ctl.mean_go ? kp[62:32] : k_ff;
      addend = (ctl.acc_sel >= 3'(NUM_DIAG)) ? {lane_sq[ctl.acc_sel], 1'b0}
                                             : {1'b0, lane_sq[ctl.acc_sel]};
      acc_in = acc_ff;
      if (ctl.acc_clr) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + 67'(addend);
      end
   end

   // Integer square root, two radicand bits per step
   always_comb begin
      rb = 65'(r_ff) + 65'(b_ff);
      v_in = v_ff;
      r_in = r_ff;
      b_in = b_ff;
      cnt_in = cnt_ff;
      root_busy_in = root_busy_ff;
      if (ctl.root_go) begin
         v_in = (|acc_ff[66:64]) ? '1 : acc_ff[63:0];
         r_in = '0;
         b_in = 64'h4000_0000_0000_0000;
         cnt_in = 6'(SQRT_STEPS);
         root_busy_in = 1'b1;
      end else if (root_busy_ff) begin
         if (65'(v_ff) >= rb) begin
            v_in = v_ff - rb[63:0];
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         cnt_in = cnt_ff - 6'd1;
         root_busy_in = (cnt_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         root_busy_ff <= 1'b0;
         mean_busy_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         root_busy_ff <= root_busy_in;
         mean_busy_ff <= mean_busy_in;
      end
      neg_ff <= neg_in;
      pp_hi_ff <= pp_hi_in;
      pp_lo_ff <= pp_lo_in;
      mquo_ff <= mquo_in;
      k_ff <= k_in;
      acc_ff <= acc_in;
      v_ff <= v_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign mean = mv[31:0];
   assign norm = r_ff[31:0];
   assign k = k_ff;
   assign stat.mean_busy = mean_busy_ff;
   assign stat.root_busy = root_busy_ff;

endmodule

// ===== sv/j2_radial_return_stress_update_core.sv =====
// Top level of the J2 radial return stress update core.
//
//   Channel  Kind        Moves
//   req_ch   sink        six deformation rate components and a time step per item
//   rsp_ch   source      six stress components and the yield flag per item
//   csr_*    APB target  lame_lambda @0x0, shear_modulus @0x4, yield_stress @0x8
//
// One item at a time. An item passes through the lane steps (first product, rate,
// second product, trial stress), the mean (start plus a registered reciprocal
// multiply by one third), deviator and square, the sum of squares over the six lanes,
// the square root and commit. A yielding item also runs the per-lane 64-bit restoring
// dividers before commit. Reset is synchronous and clears the stored stress and the
// configuration registers to zero. A stalled result sits in the output register
// while the next item is accepted; the core holds before commit only if it is full.
module j2_radial_return_stress_update_core import jrr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   jrr_req_if.sink               req_ch,
   jrr_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [15:0] {
      ST_IDLE    = 16'b0000_0000_0000_0001,
      ST_MUL1    = 16'b0000_0000_0000_0010,
      ST_RATE    = 16'b0000_0000_0000_0100,
      ST_MUL2    = 16'b0000_0000_0000_1000,
      ST_TRIAL   = 16'b0000_0000_0001_0000,
      ST_MEAN_GO = 16'b0000_0000_0010_0000,
      ST_MEAN    = 16'b0000_0000_0100_0000,
      ST_DEV     = 16'b0000_0000_1000_0000,
      ST_SQ      = 16'b0000_0001_0000_0000,
      ST_ACC     = 16'b0000_0010_0000_0000,
      ST_ROOT_GO = 16'b0000_0100_0000_0000,
      ST_ROOT    = 16'b0000_1000_0000_0000,
      ST_PREP    = 16'b0001_0000_0000_0000,
      ST_DIV_GO  = 16'b0010_0000_0000_0000,
      ST_DIV     = 16'b0100_0000_0000_0000,
      ST_COMMIT  = 16'b1000_0000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [30:0]        lambda_ff, lambda_in;
   logic [30:0]        mu_ff, mu_in;
   logic [30:0]        yield_ff, yield_in;
   q16_type            tr_ff, tr_in;
   logic [31:0]        dt_ff, dt_in;
   logic signed [63:0] plt_ff, plt_in;
   logic [2:0]         acc_cnt_ff, acc_cnt_in;
   logic               yielded_ff, yielded_in;
   logic               rsp_valid_ff, rsp_valid_in;
   q16_type            out_ff [NUM_LANES];
   q16_type            out_in [NUM_LANES];
   logic               out_yield_ff, out_yield_in;

   logic               accept;
   logic               csr_write;
   logic               commit_ok;
   logic               lanes_busy;
   q16_type            m2;
   q16_type            lt;
   lane_ctl_type       lane_ctl;
   merge_ctl_type      merge_ctl;
   merge_stat_type     merge_stat;
   q16_type            lane_rate [NUM_LANES];
   q16_type            lane_trial [NUM_LANES];
   logic [63:0]        lane_sq [NUM_LANES];
   q16_type            lane_res [NUM_LANES];
   logic [NUM_LANES-1:0] lane_busy;
   q16_type            diag_trial [NUM_DIAG];
   q16_type            mean;
   logic [31:0]        norm;
   logic [30:0]        k;

   // Configuration registers
   always_comb begin
      csr_write = csr_psel & csr_penable & csr_pwrite;
      lambda_in = lambda_ff;
      mu_in = mu_ff;
      yield_in = yield_ff;
      csr_prdata = '0;
      case (csr_reg_type'(csr_paddr[3:2]))
         REG_LAME_LAMBDA: begin
            csr_prdata = {1'b0, lambda_ff};
            if (csr_write) lambda_in = csr_pwdata[30:0];
         end
         REG_SHEAR_MODULUS: begin
            csr_prdata = {1'b0, mu_ff};
            if (csr_write) mu_in = csr_pwdata[30:0];
         end
         REG_YIELD_STRESS: begin
            csr_prdata = {1'b0, yield_ff};
            if (csr_write) yield_in = csr_pwdata[30:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end
   assign csr_pready = 1'b1;

   // Spread the item over the lanes
   always_comb begin
      lane_rate[0] = req_ch.rate_xx;
      lane_rate[1] = req_ch.rate_yy;
      lane_rate[2] = req_ch.rate_zz;
      lane_rate[3] = req_ch.rate_xy;
      lane_rate[4] = req_ch.rate_yz;
      lane_rate[5] = req_ch.rate_xz;
      for (int i = 0; i < NUM_DIAG; i++) begin
         diag_trial[i] = lane_trial[i];
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept = req_ch.valid & req_ch.ready;
   assign m2 = mu_ff[30] ? 32'sh7FFFFFFF : q16_type'({mu_ff, 1'b0});
   assign lt = mulq(66'(plt_ff));
   assign lanes_busy = |lane_busy;
   assign commit_ok = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      acc_cnt_in = acc_cnt_ff;
      yielded_in = yielded_ff;
      tr_in = tr_ff;
      dt_in = dt_ff;
      plt_in = plt_ff;
      lane_ctl = '0;
      merge_ctl = '0;
      merge_ctl.acc_sel = acc_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            lane_ctl.load = accept;
            if (accept) begin
               tr_in = sat32(66'(req_ch.rate_xx) + 66'(req_ch.rate_yy) + 66'(req_ch.rate_zz));
               dt_in = req_ch.time_step;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            lane_ctl.mul1 = 1'b1;
            plt_in = $signed({1'b0, lambda_ff}) * tr_ff;
            state_in = ST_RATE;
         end
         ST_RATE: begin
            lane_ctl.rate = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            lane_ctl.mul2 = 1'b1;
            state_in = ST_TRIAL;
         end
         ST_TRIAL: begin
            lane_ctl.trial = 1'b1;
            state_in = ST_MEAN_GO;
         end
         ST_MEAN_GO: begin
            merge_ctl.mean_go = 1'b1;
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            if (!merge_stat.mean_busy) state_in = ST_DEV;
         end
         ST_DEV: begin
            lane_ctl.dev = 1'b1;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            lane_ctl.square = 1'b1;
            merge_ctl.acc_clr = 1'b1;
            acc_cnt_in = '0;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            merge_ctl.acc_en = 1'b1;
            acc_cnt_in = acc_cnt_ff + 3'd1;
            if (acc_cnt_ff == 3'(NUM_LANES - 1)) state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            merge_ctl.root_go = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (!merge_stat.root_busy) begin
               yielded_in = (norm >= 32'(k)) && (norm != 32'd0);
               state_in = yielded_in ? ST_PREP : ST_COMMIT;
            end
         end
         ST_PREP: begin
            lane_ctl.prep = 1'b1;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            lane_ctl.div_go = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!lanes_busy) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_ok) begin
               lane_ctl.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load on commit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_yield_in = out_yield_ff;
      for (int i = 0; i < NUM_LANES; i++) begin
         out_in[i] = out_ff[i];
      end
      if (lane_ctl.commit) begin
         rsp_valid_in = 1'b1;
         out_yield_in = yielded_ff;
         for (int i = 0; i < NUM_LANES; i++) begin
            out_in[i] = lane_res[i];
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lambda_ff <= '0;
         mu_ff <= '0;
         yield_ff <= '0;
         rsp_valid_ff <= 1'b0;
         acc_cnt_ff <= '0;
         yielded_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lambda_ff <= lambda_in;
         mu_ff <= mu_in;
         yield_ff <= yield_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_cnt_ff <= acc_cnt_in;
         yielded_ff <= yielded_in;
      end
      tr_ff <= tr_in;
      dt_ff <= dt_in;
      plt_ff <= plt_in;
      out_yield_ff <= out_yield_in;
      for (int i = 0; i < NUM_LANES; i++) begin
         out_ff[i] <= out_in[i];
      end
   end

   // Component lanes
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      jrr_lane #(.IS_DIAG(g < NUM_DIAG)) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (lane_ctl),
         .rate_comp (lane_rate[g]),
         .dt        (dt_ff),
         .m2        (m2),
         .lt        (lt),
         .mean      (mean),
         .k         (k),
         .norm      (norm),
         .yielded   (yielded_ff),
         .trial     (lane_trial[g]),
         .sq        (lane_sq[g]),
         .res       (lane_res[g]),
         .busy      (lane_busy[g])
      );
   end

   jrr_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .ctl          (merge_ctl),
      .diag_trial   (diag_trial),
      .lane_sq      (lane_sq),
      .yield_stress (yield_ff),
      .mean         (mean),
      .norm         (norm),
      .k            (k),
      .stat         (merge_stat)
   );

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.stress_xx = out_ff[0];
   assign rsp_ch.stress_yy = out_ff[1];
   assign rsp_ch.stress_zz = out_ff[2];
   assign rsp_ch.stress_xy = out_ff[3];
   assign rsp_ch.stress_yz = out_ff[4];
   assign rsp_ch.stress_xz = out_ff[5];
   assign rsp_ch.yielded = out_yield_ff;

endmodule
